@@ rtl/caws_pkg.sv @@
// ----------------------------------------------------------------------------
// caws_pkg: shared types, constants and helpers of the cave automaton step
// Sizes, register codes, queue entry and result records, window rules.
// ----------------------------------------------------------------------------
package caws_pkg;

	// Grid limits
	localparam int MAX_COLS   = 32;
	localparam int MAX_ROWS   = 4096;
	localparam int COL_AW     = $clog2(MAX_COLS);
	localparam int ROW_W      = 12;
	localparam int OUT_COL_W  = 6;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int COLS_CFG_W = 6;
	localparam int ROWS_CFG_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST = 6'd32;
	localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST = 13'd32;

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - ROW_W - OUT_COL_W;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Window rule: wall when more than WALL_LIMIT of nine cells are walls
	localparam int WALL_LIMIT  = 4;
	localparam int BELOW_WALLS = 3;

	// One column of the window: bit 2 oldest row, bit 1 middle row, bit 0 newest row
	typedef logic [2:0] colvec_t;
	localparam colvec_t EDGE_COL = 3'b111;

	// Stored history of one column: bit 1 row before last, bit 0 last row
	typedef logic [1:0] hist_t;

	typedef struct packed {
		colvec_t             vec;
		logic [ROW_W-1:0]    row;
		logic [COL_AW-1:0]   col;
		logic                has_up;
		logic                row_end;
		logic                need_b;
		logic                last;
	} entry_t;

	typedef struct packed {
		logic                 wall;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 run_last;
		logic                 frame_done;
	} result_t;

	typedef enum logic [1:0] {
		BK_MAIN,
		BK_END,
		BK_FLUSH
	} bk_state_t;

	// Last column index for a written column count
	function automatic logic [COL_AW-1:0] col_limit(input logic [COLS_CFG_W-1:0] v);
		logic [COL_AW-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (v > COLS_CFG_W'(MAX_COLS)) begin
			res = COL_AW'(MAX_COLS - 1);
		end else begin
			res = COL_AW'(v - COLS_CFG_W'(1));
		end
		return res;
	endfunction

	// Last row index for a written row count
	function automatic logic [ROW_W-1:0] row_limit(input logic [ROWS_CFG_W-1:0] v);
		logic [ROW_W-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (v > ROWS_CFG_W'(MAX_ROWS)) begin
			res = ROW_W'(MAX_ROWS - 1);
		end else begin
			res = ROW_W'(v - ROWS_CFG_W'(1));
		end
		return res;
	endfunction

	// Next state of the middle cell, all three rows of the window known
	function automatic logic upper_wall(input colvec_t lc, input colvec_t mc,
	                                    input colvec_t rc);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 3; i++) begin
			n = n + 4'(lc[i]) + 4'(mc[i]) + 4'(rc[i]);
		end
		return n > 4'(WALL_LIMIT);
	endfunction

	// Next state of a last-row cell: row below the grid counts as walls
	function automatic logic lower_wall(input colvec_t lc, input colvec_t mc,
	                                    input colvec_t rc);
		logic [3:0] n;
		n = 4'(BELOW_WALLS);
		for (int i = 0; i < 2; i++) begin
			n = n + 4'(lc[i]) + 4'(mc[i]) + 4'(rc[i]);
		end
		return n > 4'(WALL_LIMIT);
	endfunction

endpackage

@@ rtl/caws_ram.sv @@
// ----------------------------------------------------------------------------
// caws_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read before write).
// ----------------------------------------------------------------------------
module caws_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/caws_front.sv @@
// ----------------------------------------------------------------------------
// caws_front: input side of the cave automaton step
// Holds configuration and raster position, keeps two rows of history per
// column in a line memory and turns each input item into a column record.
// ----------------------------------------------------------------------------
module caws_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                wall_in,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [caws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [caws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                push,
	input  logic                                push_ready,
	output caws_pkg::entry_t                    push_entry,
	output logic [caws_pkg::COL_AW-1:0]         last_col,
	output logic [caws_pkg::ROW_W-1:0]          last_row
);

	logic [caws_pkg::COLS_CFG_W-1:0] grid_cols_q;
	logic [caws_pkg::ROWS_CFG_W-1:0] grid_rows_q;
	logic [caws_pkg::COL_AW-1:0]     col_q, col_d;
	logic [caws_pkg::ROW_W-1:0]      row_q, row_d;
	logic                            accept;
	logic                            cfg_wr, cfg_hit;
	logic                            row_end, frame_end;
	logic                            fwd_q;
	caws_pkg::hist_t                 fwd_data_q;
	caws_pkg::hist_t                 ram_rdata, hist, hist_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == caws_pkg::REG_GRID_COLS ||
	                              cfg_index == caws_pkg::REG_GRID_ROWS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= caws_pkg::GRID_COLS_RST;
			grid_rows_q <= caws_pkg::GRID_ROWS_RST;
		end else if (cfg_wr) begin
			if (cfg_index == caws_pkg::REG_GRID_COLS) begin
				grid_cols_q <= cfg_data[caws_pkg::COLS_CFG_W-1:0];
			end else if (cfg_index == caws_pkg::REG_GRID_ROWS) begin
				grid_rows_q <= cfg_data[caws_pkg::ROWS_CFG_W-1:0];
			end
		end
	end

	assign last_col = caws_pkg::col_limit(grid_cols_q);
	assign last_row = caws_pkg::row_limit(grid_rows_q);

	assign s_tready  = push_ready;
	assign accept    = s_tvalid && s_tready;
	assign row_end   = col_q == last_col;
	assign frame_end = row_end && (row_q == last_row);

	// Advance the raster position
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cfg_hit) begin
			col_d = '0;
			row_d = '0;
		end else if (accept) begin
			if (frame_end) begin
				col_d = '0;
				row_d = '0;
			end else if (row_end) begin
				col_d = '0;
				row_d = row_q + caws_pkg::ROW_W'(1);
			end else begin
				col_d = col_q + caws_pkg::COL_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// Line memory: read the column of the next item ahead of time
	caws_ram #(
		.WIDTH ($bits(caws_pkg::hist_t)),
		.DEPTH (caws_pkg::MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (hist_wr),
		.raddr (col_d),
		.rdata (ram_rdata)
	);

	// Forward a write that lands on the address read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= accept && (col_d == col_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= hist_wr;
	end

	assign hist    = fwd_q ? fwd_data_q : ram_rdata;
	assign hist_wr = {hist[0], wall_in};

	// Build the column record; rows above the grid read as walls
	always_comb begin
		push_entry.vec     = {(row_q[caws_pkg::ROW_W-1:1] == '0) ? 1'b1 : hist[1],
		                      (row_q == '0) ? 1'b1 : hist[0],
		                      wall_in};
		push_entry.row     = row_q;
		push_entry.col     = col_q;
		push_entry.has_up  = (row_q != '0) && (col_q != '0);
		push_entry.row_end = row_end;
		push_entry.need_b  = row_end && (row_q != '0);
		push_entry.last    = frame_end;
	end

	assign push = accept;

endmodule

@@ rtl/caws_queue.sv @@
// ----------------------------------------------------------------------------
// caws_queue: short queue of column records between front and back
// Lets the input side keep taking items while the back side emits results.
// ----------------------------------------------------------------------------
module caws_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  caws_pkg::entry_t push_entry,
	output logic             head_valid,
	input  logic             pop,
	output caws_pkg::entry_t head
);

	caws_pkg::entry_t              slots [caws_pkg::QUEUE_DEPTH];
	logic [caws_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [caws_pkg::QUEUE_AW:0]   count_q;
	logic                          do_push, do_pop;

	assign push_ready = count_q != (caws_pkg::QUEUE_AW + 1)'(caws_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;
	assign head       = slots[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + caws_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + caws_pkg::QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (caws_pkg::QUEUE_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (caws_pkg::QUEUE_AW + 1)'(1);
			end
		end
	end

endmodule

@@ rtl/caws_back.sv @@
// ----------------------------------------------------------------------------
// caws_back: result side of the cave automaton step
// Slides a three-column window over the column records, emits the cells of
// the row above, keeps the last row's next states and flushes them at frame end.
// ----------------------------------------------------------------------------
module caws_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  caws_pkg::entry_t             head,
	output logic                         pop,
	input  logic [caws_pkg::COL_AW-1:0]  last_col,
	output logic                         out_valid,
	input  logic                         out_ready,
	output caws_pkg::result_t            out_res
);

	caws_pkg::bk_state_t          state_q, state_d;
	logic [caws_pkg::COL_AW-1:0]  cnt_q;
	caws_pkg::colvec_t            w1_q, w2_q;
	logic [caws_pkg::MAX_COLS-1:0] lo_q;
	logic                         out_valid_q;
	caws_pkg::result_t            out_q;
	logic                         ld, emit, done, flush_end;
	caws_pkg::result_t            res;
	caws_pkg::colvec_t            left_a, left_b;
	logic                         up_a, up_b, lo_a, lo_b;

	assign ld        = !out_valid_q || out_ready;
	assign flush_end = cnt_q == last_col;

	// Window for the cell left of the current column and for the row-end cell
	assign left_a = (head.col[caws_pkg::COL_AW-1:1] == '0) ? caws_pkg::EDGE_COL : w2_q;
	assign left_b = (head.col == '0) ? caws_pkg::EDGE_COL : w1_q;
	assign up_a   = caws_pkg::upper_wall(left_a, w1_q, head.vec);
	assign lo_a   = caws_pkg::lower_wall(left_a, w1_q, head.vec);
	assign up_b   = caws_pkg::upper_wall(left_b, head.vec, caws_pkg::EDGE_COL);
	assign lo_b   = caws_pkg::lower_wall(left_b, head.vec, caws_pkg::EDGE_COL);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			caws_pkg::BK_MAIN: begin
				if (head_valid && done) begin
					if (head.need_b) begin
						state_d = caws_pkg::BK_END;
					end else if (head.last) begin
						state_d = caws_pkg::BK_FLUSH;
					end
				end
			end
			caws_pkg::BK_END: begin
				if (done) begin
					state_d = head.last ? caws_pkg::BK_FLUSH : caws_pkg::BK_MAIN;
				end
			end
			caws_pkg::BK_FLUSH: begin
				if (done && flush_end) begin
					state_d = caws_pkg::BK_MAIN;
				end
			end
			default: state_d = caws_pkg::BK_MAIN;
		endcase
	end

	// Outputs per state: result to emit, step done, entry retired
	always_comb begin
		emit = 1'b0;
		done = 1'b0;
		pop  = 1'b0;
		res  = '0;
		case (state_q)
			caws_pkg::BK_MAIN: begin
				emit         = head_valid && head.has_up;
				res.wall     = up_a;
				res.row      = head.row - caws_pkg::ROW_W'(1);
				res.col      = caws_pkg::OUT_COL_W'(head.col - caws_pkg::COL_AW'(1));
				res.run_last = !head.need_b && !head.last;
				done         = head_valid && (!head.has_up || ld);
				pop          = done && !head.need_b && !head.last;
			end
			caws_pkg::BK_END: begin
				emit         = 1'b1;
				res.wall     = up_b;
				res.row      = head.row - caws_pkg::ROW_W'(1);
				res.col      = caws_pkg::OUT_COL_W'(head.col);
				res.run_last = !head.last;
				done         = ld;
				pop          = done && !head.last;
			end
			caws_pkg::BK_FLUSH: begin
				emit           = 1'b1;
				res.wall       = lo_q[cnt_q];
				res.row        = head.row;
				res.col        = caws_pkg::OUT_COL_W'(cnt_q);
				res.run_last   = flush_end;
				res.frame_done = flush_end;
				done           = ld;
				pop            = done && flush_end;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// State and flush counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caws_pkg::BK_MAIN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == caws_pkg::BK_FLUSH && done) begin
				cnt_q <= flush_end ? '0 : cnt_q + caws_pkg::COL_AW'(1);
			end
		end
	end

	// Shift the column window as each record retires
	always_ff @(posedge clk) begin
		if (pop) begin
			w2_q <= w1_q;
			w1_q <= head.vec;
		end
	end

	// Hold next states of the newest row for the frame-end flush
	always_ff @(posedge clk) begin
		if (state_q == caws_pkg::BK_MAIN && head_valid) begin
			if (head.col != '0) begin
				lo_q[head.col - caws_pkg::COL_AW'(1)] <= lo_a;
			end
			if (head.row_end) begin
				lo_q[head.col] <= lo_b;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

@@ rtl/cave_automaton_window_step.sv @@
// ----------------------------------------------------------------------------
// cave_automaton_window_step: one generation of the cave cellular automaton
// Raster-order grid in, next-generation cells out with their coordinates.
// ----------------------------------------------------------------------------
// s_* takes one current cell per item (wall bit in tdata bit 0), row by row,
// columns ascending. m_* gives next-generation cells; tlast marks the final
// result an input item causes, tuser marks the grid's last cell. cfg_* writes
// grid_cols (index 0) or grid_rows (index 1); the user must write only while
// the block is idle, which the block does not enforce. Any such write restarts
// the frame at row 0, column 0. An item can be accepted every cycle while the
// queue has room. The first result it causes passes through the queue and the
// output register to m_tvalid. The back side handles each item in its main
// state, adds an end state on each row's last item from the second row on, and
// flushes the final row, one result per column, after the frame's last item;
// the four-entry queue absorbs short bursts, so input can continue meanwhile.
// Reset sets a 32 x 32 grid and position zero; the column history memory is
// not cleared, as every entry is written in a frame before it is read.
// With m_tready low the output register holds, the queue fills and s_tready
// drops once it is full.
// ----------------------------------------------------------------------------
module cave_automaton_window_step (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [caws_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] wall_in
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [caws_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] wall_out, [12:1] out_row, [18:13] out_col
	output logic                                 m_tlast,
	output logic                                 m_tuser,   // [0] frame_done
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [caws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [caws_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                         push, push_ready;
	caws_pkg::entry_t             push_entry;
	logic                         head_valid, pop;
	caws_pkg::entry_t             head;
	logic [caws_pkg::COL_AW-1:0]  last_col;
	logic [caws_pkg::ROW_W-1:0]   last_row;
	caws_pkg::result_t            res;

	// Accept items and build column records
	caws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.wall_in    (s_tdata[0]),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.last_col   (last_col),
		.last_row   (last_row)
	);

	// Decouple front and back
	caws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	// Evaluate windows and emit results
	caws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.last_col   (last_col),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	// Pack the result item
	assign m_tdata = {{caws_pkg::OUT_PAD_W{1'b0}}, res.col, res.row, res.wall};
	assign m_tlast = res.run_last;
	assign m_tuser = res.frame_done;

`ifndef SYNTHESIS
	// The grid's last cell always ends its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.frame_done |-> res.run_last)
		else $error("frame_done without run_last");

	// The grid's last cell sits in the last column
	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.frame_done |-> res.col == caws_pkg::OUT_COL_W'(last_col))
		else $error("frame_done off the last column");

	// The grid's last cell sits in the last row
	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.frame_done |-> res.row == last_row)
		else $error("frame_done off the last row");
`endif

endmodule

@@ dv/cave_automaton_window_step_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cave_automaton_window_step_tb: self-checking bench for the cave automaton step
// Streams raster grids through the block under changing idle and stall
// patterns and checks every next-generation cell, its coordinates and its
// tlast/tuser marks against a behavioral model of the 4-5 window rule.
// ----------------------------------------------------------------------------
module cave_automaton_window_step_tb;
	import caws_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int ERR_PRINT_MAX = 40;
	localparam int PHASE_ITEMS   = 5;
	localparam int FRAME_CAP     = 10;
	localparam int TALL_ITEMS    = 4;
	localparam int END_WAIT      = 20000;
	localparam int PLAN_LEN      = 29;

	// Indexes past the register list; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Sender idle and receiver stall percentages, one pair per phase
	localparam int IDLE_BY_PHASE  [4] = '{0, 81, 0, 22};
	localparam int STALL_BY_PHASE [4] = '{0, 0, 81, 22};

	typedef enum logic {
		ROW_CELL,
		ROW_REG
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t             kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   wall;
		logic                   typed;
		result_t                want;
	} plan_row_t;

	localparam result_t NO_CELL   = '0;
	// A lone cell sees eight outside walls, so it always comes out wall
	localparam result_t LONE_WALL = '{wall: 1'b1, row: '0, col: '0,
	                                  run_last: 1'b1, frame_done: 1'b1};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // [0] wall_in
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [0] wall_out, [12:1] out_row, [18:13] out_col
	logic                   m_tlast;    // run_last
	logic                   m_tuser;    // [0] frame_done
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Grid model state
	logic [2:0]             hist [MAX_COLS];
	int                     at_row;
	int                     at_col;
	int                     cur_slot;
	logic [COLS_CFG_W-1:0]  cfg_cols;
	logic [ROWS_CFG_W-1:0]  cfg_rows;
	result_t                fresh_cells [$];
	result_t                cells_due [$];
	result_t                seen_want;

	int                     err_count;
	int                     items_sent;
	int                     idle_pct;
	int                     stall_pct;
	int                     hold_left;
	int                     cycles;
	logic                   hold_req;
	plan_row_t              plan [PLAN_LEN];

	cave_automaton_window_step dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= ERR_PRINT_MAX) begin
			$display("[%0t] ERROR %s", $time, msg);
		end
	endtask

	function automatic int live_cols();
		if (cfg_cols == '0) return 1;
		if (cfg_cols > COLS_CFG_W'(MAX_COLS)) return MAX_COLS;
		return int'(cfg_cols);
	endfunction

	function automatic int live_rows();
		if (cfg_rows == '0) return 1;
		if (cfg_rows > ROWS_CFG_W'(MAX_ROWS)) return MAX_ROWS;
		return int'(cfg_rows);
	endfunction

	// Wall bit of one window position; outside the grid counts as wall
	function automatic int cell_at(input int rr, input int cc, input int newest);
		int age;
		if (rr < 0 || rr >= live_rows() || cc < 0 || cc >= live_cols()) return 1;
		age = newest - rr;
		if (age < 0 || age > 2) return 1;
		return int'(hist[cc][(cur_slot + 3 - age) % 3]);
	endfunction

	function automatic logic next_wall(input int cr, input int cc, input int newest);
		int n;
		n = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				n += cell_at(cr + dr, cc + dc, newest);
		return n > WALL_LIMIT;
	endfunction

	function automatic void add_cell(input int cr, input int cc, input int newest,
	                                 input logic done);
		result_t res;
		res.wall       = next_wall(cr, cc, newest);
		res.row        = ROW_W'(cr);
		res.col        = OUT_COL_W'(cc);
		res.run_last   = 1'b0;
		res.frame_done = done;
		fresh_cells = {fresh_cells, res};
	endfunction

	// Take one raster cell, collect the cells it completes into fresh_cells
	function automatic void advance_grid(input logic wall);
		int rows;
		int cols;
		int r;
		int c;
		logic at_end;
		rows = live_rows();
		cols = live_cols();
		r = at_row;
		c = at_col;
		fresh_cells.delete();
		hist[c][cur_slot] = wall;
		at_end = (r == rows - 1) && (c == cols - 1);
		if (r >= 1) begin
			if (c >= 1) add_cell(r - 1, c - 1, r, 1'b0);
			if (c == cols - 1) add_cell(r - 1, c, r, 1'b0);
		end
		// Final cell of the frame flushes the whole last row
		if (at_end) begin
			for (int k = 0; k < cols; k++)
				add_cell(r, k, r, k == cols - 1);
		end
		if (fresh_cells.size() > 0) begin
			fresh_cells[fresh_cells.size() - 1].run_last = 1'b1;
		end
		// Advance the raster position
		if (at_end) begin
			at_row = 0;
			at_col = 0;
			cur_slot = 0;
		end else if (c == cols - 1) begin
			at_col = 0;
			at_row = r + 1;
			cur_slot = (cur_slot + 1) % 3;
		end else begin
			at_col = c + 1;
		end
	endfunction

	// Any write to a real register restarts the frame
	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_GRID_COLS) begin
			cfg_cols = data[COLS_CFG_W-1:0];
		end else if (idx == REG_GRID_ROWS) begin
			cfg_rows = data[ROWS_CFG_W-1:0];
		end else begin
			return;
		end
		at_row = 0;
		at_col = 0;
		cur_slot = 0;
	endfunction

	// Offer one cell, with random idle cycles ahead of it
	task automatic send_cell(input logic wall, input logic typed, input result_t want);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(wall);
		do @(posedge clk); while (!s_tready);
		advance_grid(wall);
		if (typed) begin
			cells_due = {cells_due, want};
		end else begin
			cells_due = {cells_due, fresh_cells};
		end
	endtask

	task automatic send_frame(input int count, input int density);
		repeat (count) begin
			send_cell(logic'($urandom_range(99) < density), 1'b0, NO_CELL);
			items_sent++;
		end
	endtask

	// Drop valid and wait until every outstanding cell is out
	task automatic settle_all();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cells_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		settle_all();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random grid size, random fill; some frames are cut short
	task automatic random_frame();
		logic [COLS_CFG_W-1:0] cols_val;
		logic [ROWS_CFG_W-1:0] rows_val;
		int pick;
		int total;
		pick = $urandom_range(99);
		if (pick < 5) cols_val = '0;
		else if (pick < 80) cols_val = COLS_CFG_W'($urandom_range(1, 6));
		else if (pick < 90) cols_val = COLS_CFG_W'($urandom_range(7, 32));
		else cols_val = COLS_CFG_W'($urandom_range(33, 63));
		pick = $urandom_range(99);
		if (pick < 5) rows_val = '0;
		else if (cols_val > 8) rows_val = ROWS_CFG_W'($urandom_range(1, 3));
		else rows_val = ROWS_CFG_W'($urandom_range(1, 6));
		pick = $urandom_range(3);
		if (pick != 1) begin
			write_reg(REG_GRID_COLS,
			          {(CFG_DATA_W - COLS_CFG_W)'($urandom_range(127)), cols_val});
		end
		if (pick != 0) write_reg(REG_GRID_ROWS, rows_val);
		if (pick == 3) begin
			write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2,
			          CFG_DATA_W'($urandom_range(8191)));
		end
		total = live_cols() * live_rows();
		if (total > FRAME_CAP) total = FRAME_CAP;
		if ($urandom_range(99) < 15) total = $urandom_range(1, total);
		send_frame(total, $urandom_range(100));
	endtask

	// Receiver: long hold-off on request, else random stalls
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each accepted result with the oldest outstanding cell
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cells_due.size() == 0) begin
				note_error($sformatf("unexpected result row %0d col %0d",
				                     m_tdata[ROW_W:1], m_tdata[ROW_W+OUT_COL_W:ROW_W+1]));
			end else begin
				seen_want = cells_due.pop_front();
				if (m_tdata[0] !== seen_want.wall ||
				    m_tdata[ROW_W:1] !== seen_want.row ||
				    m_tdata[ROW_W+OUT_COL_W:ROW_W+1] !== seen_want.col ||
				    m_tlast !== seen_want.run_last ||
				    m_tuser !== seen_want.frame_done) begin
					note_error($sformatf(
						"got wall %b (%0d,%0d) last %b done %b, want wall %b (%0d,%0d) last %b done %b",
						m_tdata[0], m_tdata[ROW_W:1], m_tdata[ROW_W+OUT_COL_W:ROW_W+1],
						m_tlast, m_tuser, seen_want.wall, seen_want.row, seen_want.col,
						seen_want.run_last, seen_want.frame_done));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cave_automaton_window_step: mismatch");
			$finish;
		end
	end

	initial begin
		int mark;
		int waited;
		plan = '{
			// default 32 x 32 grid, first row gives nothing
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			// zero counts act as one: a lone cell
			'{ROW_REG,  REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_REG,  REG_GRID_ROWS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b1, LONE_WALL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b1, LONE_WALL},
			// 2 x 2 grid, solid then open
			'{ROW_REG,  REG_GRID_COLS, 13'd2, 1'b0, 1'b0, NO_CELL},
			'{ROW_REG,  REG_GRID_ROWS, 13'd2, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			// 3 x 3 grid; unused indexes written mid-frame must not restart it
			'{ROW_REG,  REG_GRID_COLS, 13'd3, 1'b0, 1'b0, NO_CELL},
			'{ROW_REG,  REG_GRID_ROWS, 13'd3, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_REG,  REG_SPARE_3,   13'h1555, 1'b0, 1'b0, NO_CELL},
			'{ROW_REG,  REG_SPARE_2,   13'h0AAA, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b1, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL},
			'{ROW_CELL, REG_GRID_COLS, 13'd0, 1'b0, 1'b0, NO_CELL}
		};
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		hold_left = 0;
		err_count = 0;
		items_sent = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		foreach (hist[i]) hist[i] = '0;
		cfg_cols = GRID_COLS_RST;
		cfg_rows = GRID_ROWS_RST;
		at_row = 0;
		at_col = 0;
		cur_slot = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
			else send_cell(plan[i].wall, plan[i].typed, plan[i].want);
		end

		// Extremes: column count above the limit on a one-row grid, then row
		// counts at and above 4096 on one column, cut short
		write_reg(REG_GRID_COLS, 13'h1FFE);
		write_reg(REG_GRID_ROWS, 13'd1);
		send_frame(live_cols() * live_rows(), 50);
		write_reg(REG_GRID_COLS, 13'h1FC1);
		write_reg(REG_GRID_ROWS, 13'h1FFF);
		send_frame(TALL_ITEMS, 30);
		write_reg(REG_GRID_ROWS, 13'h1000);
		send_frame(TALL_ITEMS, 70);

		// Random frames under each idle and stall pattern
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = IDLE_BY_PHASE[ph];
			stall_pct = STALL_BY_PHASE[ph];
			mark = items_sent;
			while (items_sent - mark < PHASE_ITEMS) random_frame();
		end

		// Back-pressure: long receiver hold, then a full pause mid-frame
		idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_GRID_COLS, 13'd2);
		write_reg(REG_GRID_ROWS, 13'd8);
		@(posedge clk);
		hold_req = 1'b1;
		send_frame(10, 50);
		settle_all();
		send_frame(6, 50);

		// Drain and close out
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (cells_due.size() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (cells_due.size() != 0) begin
			note_error($sformatf("%0d result cells never arrived", cells_due.size()));
		end
		if (err_count == 0) begin
			$display("cave_automaton_window_step: match");
		end else begin
			$display("cave_automaton_window_step: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/caws_pkg.sv
rtl/caws_ram.sv
rtl/caws_front.sv
rtl/caws_queue.sv
rtl/caws_back.sv
rtl/cave_automaton_window_step.sv
dv/cave_automaton_window_step_tb.sv
